// File: hdl/swm_pkg.sv
// Shared types and fixed widths for the sliding window min/max/mean filter.
package swm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int MEAN_W   = 40;
  localparam int CFG_W    = 5;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start_of_sequence;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] window_max;
    logic signed [SAMPLE_W-1:0] window_min;
    logic signed [MEAN_W-1:0]   window_mean_q8;
  } out_t;

endpackage

// File: hdl/sliding_window_min_max_mean.sv
// Sliding window filter giving max, min and Q8 mean over the newest window_size samples.
//
// Each accepted request pushes one sample into a row of WINDOW_MAX cells. A sample that does
// not yet complete a window (fewer than window_size samples since the last start of sequence)
// leaves the block idle, so the next request can follow at once. A sample that completes a
// window launches a token down the cell row, one cell per cycle, which gathers the maximum,
// minimum and sum of the newest window_size cells; a bit-serial divider then forms
// sum * 256 / k, truncated toward zero, one quotient bit per cycle. Such a request holds the
// block: in_stall is high while the token runs down the row, while the divider works and
// until the result has entered the output register. The finished result sits in that
// register, so the next request is taken while it waits on out_stall.
// Window sizes of zero read as one and sizes above WINDOW_MAX read as WINDOW_MAX. Only the low
// SAMPLE_BITS bits of a sample are used, sign-extended. The window size may only be written
// while the block is idle.
module sliding_window_min_max_mean #(
  parameter int WINDOW_MAX  = 16,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  swm_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output swm_pkg::out_t             out_data,
  input  logic                      cfg_write_en,
  input  logic [swm_pkg::CFG_W-1:0] cfg_write_data
);

  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX);
  localparam int NW    = SUM_W + 8;
  localparam int FW    = $clog2(WINDOW_MAX + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] MOST_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  logic [1:0]                state;
  logic [swm_pkg::CFG_W-1:0] window_size;
  logic [swm_pkg::CFG_W-1:0] k_eff;
  logic [swm_pkg::CFG_W-1:0] k_held;
  logic [FW-1:0]             fill;
  logic [FW-1:0]             fill_base;
  logic [FW-1:0]             fill_next;
  logic                      accept;
  logic                      full;
  logic                      launch;

  logic signed [SAMPLE_BITS-1:0] samp   [0:WINDOW_MAX];
  logic                          tok    [0:WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] pmax   [0:WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] pmin   [0:WINDOW_MAX];
  logic signed [SUM_W-1:0]       psum   [0:WINDOW_MAX];

  logic signed [SAMPLE_BITS-1:0] res_max;
  logic signed [SAMPLE_BITS-1:0] res_min;
  logic signed [swm_pkg::MEAN_W-1:0] res_mean;

  logic signed [NW-1:0] num_s;
  logic [NW-1:0]        num_mag;
  logic                 neg;
  logic                 div_start;
  logic                 div_done;
  logic [NW-1:0]        quot;
  logic signed [NW:0]   quot_s;
  logic signed [63:0]   quot_wide;

  // The block takes a request only while no window is in flight.
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Configuration register; zero reads as one, oversize saturates at the row length.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swm_pkg::CFG_W'(16);
    end else if (cfg_write_en) begin
      window_size <= cfg_write_data;
    end
  end

  always_comb begin
    if (window_size == '0) begin
      k_eff = swm_pkg::CFG_W'(1);
    end else if (32'(window_size) > WINDOW_MAX) begin
      k_eff = swm_pkg::CFG_W'(WINDOW_MAX);
    end else begin
      k_eff = window_size;
    end
  end

  // Fill count restarts on a start of sequence and saturates at the row length.
  always_comb begin
    fill_base = in_data.start_of_sequence ? '0 : fill;
    if (32'(fill_base) < WINDOW_MAX) begin
      fill_next = fill_base + 1'b1;
    end else begin
      fill_next = fill_base;
    end
  end

  assign full = (32'(fill_next) >= 32'(k_eff));

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      k_held <= k_eff;
    end
  end

  // The token is registered, so it enters the first cell in the cycle after the sample has shifted in.
  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= 1'b0;
    end else begin
      launch <= accept && full;
    end
  end

  assign samp[0] = $signed(in_data.sample[SAMPLE_BITS-1:0]);
  assign tok[0]  = launch;
  assign pmax[0] = MOST_NEG;
  assign pmin[0] = MOST_POS;
  assign psum[0] = '0;

  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
    swm_cell #(
      .INDEX       (j),
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_W       (SUM_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (accept),
      .k          (k_held),
      .sample_in  (samp[j]),
      .sample_out (samp[j+1]),
      .tok_in     (tok[j]),
      .max_in     (pmax[j]),
      .min_in     (pmin[j]),
      .sum_in     (psum[j]),
      .tok_out    (tok[j+1]),
      .max_out    (pmax[j+1]),
      .min_out    (pmin[j+1]),
      .sum_out    (psum[j+1])
    );
  end

  // The divider works on the magnitude of sum * 256; the sign is put back afterward,
  // which gives truncation toward zero.
  assign num_s     = $signed({psum[WINDOW_MAX], 8'h00});
  assign num_mag   = num_s[NW-1] ? NW'(-num_s) : NW'(num_s);
  assign div_start = (state == ST_SCAN) && tok[WINDOW_MAX];

  swm_div #(
    .NW (NW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num_mag),
    .divisor  (k_held),
    .done     (div_done),
    .quotient (quot)
  );

  assign quot_s    = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign quot_wide = 64'(quot_s);

  always_ff @(posedge clk) begin
    if (div_start) begin
      res_max <= pmax[WINDOW_MAX];
      res_min <= pmin[WINDOW_MAX];
      neg     <= psum[WINDOW_MAX][SUM_W-1];
    end
    if (state == ST_DIV && div_done) begin
      res_mean <= quot_wide[swm_pkg::MEAN_W-1:0];
    end
  end

  // Sequencer: idle, token running down the row, dividing, and waiting for the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && full) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tok[WINDOW_MAX]) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      out_data.window_max     <= swm_pkg::SAMPLE_W'(res_max);
      out_data.window_min     <= swm_pkg::SAMPLE_W'(res_min);
      out_data.window_mean_q8 <= res_mean;
    end
  end

endmodule

// File: hdl/swm_cell.sv
// One window cell: holds one sample and folds it into the partial max/min/sum passing by.
module swm_cell #(
  parameter int INDEX       = 0,
  parameter int SAMPLE_BITS = 32,
  parameter int SUM_W       = 36
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          shift,
  input  logic [swm_pkg::CFG_W-1:0]     k,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  input  logic                          tok_in,
  input  logic signed [SAMPLE_BITS-1:0] max_in,
  input  logic signed [SAMPLE_BITS-1:0] min_in,
  input  logic signed [SUM_W-1:0]       sum_in,
  output logic                          tok_out,
  output logic signed [SAMPLE_BITS-1:0] max_out,
  output logic signed [SAMPLE_BITS-1:0] min_out,
  output logic signed [SUM_W-1:0]       sum_out
);

  logic signed [SAMPLE_BITS-1:0] held;
  logic                          active;

  // Only the newest k cells take part in the window.
  assign active = (32'(k) > 32'(INDEX));

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= sample_in;
    end
  end

  assign sample_out = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (active && held > max_in) begin
      max_out <= held;
    end else begin
      max_out <= max_in;
    end
    if (active && held < min_in) begin
      min_out <= held;
    end else begin
      min_out <= min_in;
    end
    if (active) begin
      sum_out <= sum_in + SUM_W'(held);
    end else begin
      sum_out <= sum_in;
    end
  end

endmodule

// File: hdl/swm_div.sv
// Bit-serial restoring divider for an unsigned dividend over the 5-bit window size.
module swm_div #(
  parameter int NW = 44
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [NW-1:0]             dividend,
  input  logic [swm_pkg::CFG_W-1:0] divisor,
  output logic                      done,
  output logic [NW-1:0]             quotient
);

  localparam int CW = (NW > 1) ? $clog2(NW) : 1;

  logic                      busy;
  logic [CW-1:0]             cnt;
  logic [NW-1:0]             acc;
  logic [swm_pkg::CFG_W-1:0] rem;
  logic [swm_pkg::CFG_W:0]   trial;
  logic                      ge;
  logic [swm_pkg::CFG_W:0]   diff;

  assign trial = {rem, acc[NW-1]};
  assign ge    = (trial >= {1'b0, divisor});
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
    end else if (busy) begin
      acc <= {acc[NW-2:0], ge};
      rem <= ge ? diff[swm_pkg::CFG_W-1:0] : trial[swm_pkg::CFG_W-1:0];
    end
  end

  assign quotient = acc;

endmodule

// File: hdl/swm_chk.sv
// Port-level checks for the sliding window filter, bound to the top level.
module swm_chk (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input swm_pkg::out_t out_data
);

  // A result waiting on the consumer stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // A new result only appears at the end of a busy span.
  a_new_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a window in flight");

  // The block only goes busy after taking a request.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid))
    else $error("stall raised without a request");

endmodule

bind sliding_window_min_max_mean swm_chk u_swm_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: test/sliding_window_min_max_mean_test.sv
// Self-checking testbench for the sliding window min/max/mean filter.
module sliding_window_min_max_mean_test;

  // Depth of the window store in the block as instantiated here.
  localparam int WINDOW_DEPTH = 16;

  // BUSY_CYCLES is how long a sample that completes a window holds the block, set by the
  // length of the cell row and the divider width; the settle time leaves margin beyond it.
  localparam int BUSY_CYCLES   = WINDOW_DEPTH + (swm_pkg::SAMPLE_W + 4 + 8) + 4;
  localparam int SETTLE_CYCLES = 2 * BUSY_CYCLES;

  // Cycles without any accepted request on either side before the run is declared hung.
  localparam int HANG_LIMIT = 4000;

  localparam int ITEMS_PER_PHASE = 160;

  // Holds a private copy of the filter state and the queue of windows still to come out.
  class window_scoreboard;
    logic [swm_pkg::CFG_W-1:0]          size_reg = 5'd16;
    logic signed [swm_pkg::SAMPLE_W-1:0] history [WINDOW_DEPTH];
    int                                 fill = 0;
    swm_pkg::out_t                      pending_windows [$];
    int                                 errors = 0;

    function void set_size(input logic [swm_pkg::CFG_W-1:0] value);
      size_reg = value;
    endfunction

    function int outstanding();
      return pending_windows.size();
    endfunction

    // Pushes one accepted request into the window and queues the result it completes.
    function void note_request(input swm_pkg::in_t req);
      int     k;
      longint total;
      longint mean;
      logic signed [swm_pkg::SAMPLE_W-1:0] hi;
      logic signed [swm_pkg::SAMPLE_W-1:0] lo;
      swm_pkg::out_t want;
      k = int'(size_reg);
      if (k < 1) k = 1;
      if (k > WINDOW_DEPTH) k = WINDOW_DEPTH;
      if (req.start_of_sequence) fill = 0;
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = req.sample;
      if (fill < WINDOW_DEPTH) fill++;
      if (fill < k) return;
      hi = history[0];
      lo = history[0];
      total = 0;
      for (int i = 0; i < k; i++) begin
        if (history[i] > hi) hi = history[i];
        if (history[i] < lo) lo = history[i];
        total += history[i];
      end
      // Signed 64-bit division truncates toward zero, as the block does.
      mean = (total * 256) / longint'(k);
      want.window_max     = hi;
      want.window_min     = lo;
      want.window_mean_q8 = mean[swm_pkg::MEAN_W-1:0];
      pending_windows.push_back(want);
    endfunction

    function void flag(input string field, input longint want_v, input longint got_v);
      errors++;
      $error("%s: expected %0d, got %0d", field, want_v, got_v);
    endfunction

    function void check_result(input swm_pkg::out_t got);
      swm_pkg::out_t want;
      if (pending_windows.size() == 0) begin
        errors++;
        $error("window result with no window pending: max %0d min %0d mean %0d",
               got.window_max, got.window_min, got.window_mean_q8);
        return;
      end
      want = pending_windows.pop_front();
      if (got.window_max !== want.window_max)
        flag("window_max", want.window_max, got.window_max);
      if (got.window_min !== want.window_min)
        flag("window_min", want.window_min, got.window_min);
      if (got.window_mean_q8 !== want.window_mean_q8)
        flag("window_mean_q8", want.window_mean_q8, got.window_mean_q8);
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  swm_pkg::in_t              in_data = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  swm_pkg::out_t             out_data;
  logic                      cfg_write_en = 1'b0;
  logic [swm_pkg::CFG_W-1:0] cfg_write_data = '0;

  // When set, neither side inserts idle cycles, so the block sees back-to-back traffic.
  bit               no_gaps = 1'b0;
  int               hang_count = 0;

  window_scoreboard sb;

  always #1 clk = ~clk;

  sliding_window_min_max_mean u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  // All block outputs are read in the active region of the rising edge, so they still hold
  // the values from before the edge; our own inputs only change through nonblocking writes.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // The result side stalls in about one cycle out of ten unless gaps are switched off.
  always @(posedge clk) begin
    out_stall <= !no_gaps && ($urandom_range(99) < 10);
  end

  // Watchdog: any accepted request on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      hang_count <= 0;
    end else if (hang_count >= HANG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      hang_count <= hang_count + 1;
    end
  end

  // Offers one request and returns in the step of the edge at which it was taken. Idle
  // cycles, if any, come first with valid low; a valid that stays high is never dropped.
  task automatic send_request(input logic [swm_pkg::SAMPLE_W-1:0] value, input logic first);
    swm_pkg::in_t req;
    req.sample            = value;
    req.start_of_sequence = first;
    while (!no_gaps && ($urandom_range(99) < 10)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
  endtask

  // Drops valid, waits for every pending window, then gives the block time to finish any
  // work that produces no result before the register may be touched.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window_size(input logic [swm_pkg::CFG_W-1:0] value);
    drain_block();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    sb.set_size(value);
  endtask

  // Random samples lean on the extremes and on small values so that ties and sign changes
  // show up often; the rest are full-width random words.
  function automatic logic [swm_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF - $urandom_range(3);
      3: return 32'h8000_0000 + $urandom_range(3);
      4: return $urandom_range(16) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  logic [swm_pkg::CFG_W-1:0] phase_sizes [8] = '{5'd2, 5'd16, 5'd17, 5'd1, 5'd8, 5'd31, 5'd15,
                                                 5'd0};
  logic [swm_pkg::SAMPLE_W-1:0] corner_samples [16] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
    32'h0000_0001, 32'h7FFF_FFFE, 32'h8000_0001, 32'h5555_5555,
    32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h8000_0000, 32'hFFFF_FFFE, 32'h0000_00FF, 32'h7FFF_FFFF
  };

  initial begin
    bit choppy;
    logic first;
    sb = new;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The reset window of sixteen is filled with extremes from a fresh
    // sequence; the sixteenth sample gives the first window and the next one slides it.
    for (int i = 0; i < 16; i++) send_request(corner_samples[i], i == 0);
    send_request(32'h8000_0000, 1'b0);

    // A size of zero must behave as one. The first two carry no start, so the size changes
    // in the middle of a full sequence; every sample gives a window at once.
    write_window_size(5'd0);
    send_request(32'h8000_0000, 1'b0);
    send_request(32'h7FFF_FFFF, 1'b0);
    send_request(32'hFFFF_FFFF, 1'b1);

    // A size above the store depth must saturate to sixteen. The new sequence begun above
    // holds one sample, so these give no window until sixteen have been taken.
    write_window_size(5'd31);
    send_request(32'h8000_0000, 1'b0);
    send_request(32'h0000_0001, 1'b0);
    send_request(32'h7FFF_FFFF, 1'b1);

    // Random phases over a spread of sizes, the extremes among them. Each phase carries on
    // the sequence of the last one, so a size change mid-sequence happens at every boundary.
    for (int p = 0; p < 12; p++) begin
      write_window_size(p < 8 ? phase_sizes[p] : swm_pkg::CFG_W'($urandom_range(31)));
      // One whole phase runs with no idling on either side.
      no_gaps = (p == 3);
      choppy = 1'b0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Mostly long sequences that fill the window, with bursts of frequent starts that
        // break sequences before they complete.
        if (i % 16 == 0) choppy = ($urandom_range(9) == 0);
        first = $urandom_range(99) < (choppy ? 30 : 2);
        send_request(pick_sample(), first);
      end
      no_gaps = 1'b0;
    end

    drain_block();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sliding_window_min_max_mean.f
hdl/swm_pkg.sv
hdl/swm_cell.sv
hdl/swm_div.sv
hdl/sliding_window_min_max_mean.sv
hdl/swm_chk.sv
test/sliding_window_min_max_mean_test.sv
